[design/fbh_pkg.sv]
// ----------------------------------------------------------------------------
// fbh_pkg: shared types and constants for the frame/batch histogram
// Field widths, register indexes, command kinds and state encodings.
// ----------------------------------------------------------------------------
package fbh_pkg;

    localparam int TIME_W      = 32;
    localparam int BATCH_W     = 20;
    localparam int DIV_W       = 16;
    localparam int COLSEL_W    = 10;
    localparam int COUNT_W     = 32;
    localparam int LEVEL_W     = 8;
    localparam int ROW_OUT_W   = 6;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;
    localparam int S_DATA_W    = 64;
    localparam int M_DATA_W    = 40;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_TIME_FLOOR     = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TIME_BIN_WIDTH = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BATCH_DIVISOR  = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_COLOR_MODE     = 8'd3;

    // Reset values of the configuration registers
    localparam logic [TIME_W-1:0] TIME_FLOOR_RST     = 32'd0;
    localparam logic [TIME_W-1:0] TIME_BIN_WIDTH_RST = 32'd1000;
    localparam logic [DIV_W-1:0]  BATCH_DIVISOR_RST  = 16'd16;
    localparam logic              COLOR_MODE_RST     = 1'b0;

    // Request / command kinds
    localparam logic REQ_RECORD  = 1'b0;
    localparam logic REQ_READOUT = 1'b1;

    // Color mode codes
    localparam logic COLOR_GREEN = 1'b0;
    localparam logic COLOR_RED   = 1'b1;

    localparam logic [LEVEL_W-1:0] LEVEL_SCALE = 8'd255;
    localparam logic [LEVEL_W-1:0] ALPHA_ON    = 8'd128;

    typedef struct packed {
        logic [TIME_W-1:0] time_floor;
        logic [TIME_W-1:0] time_bin_width;
        logic [DIV_W-1:0]  batch_divisor;
        logic              color_mode;
    } fbh_cfg_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIVIDE,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_REC_WRITE,
        B_SCAN,
        B_NORM_LOAD,
        B_NORM_DIV,
        B_EMIT
    } back_state_t;

endpackage

[design/frame_batch_histogram.sv]
// ----------------------------------------------------------------------------
// frame_batch_histogram: 2-D histogram of frame time against batch count
// Records frames into a counter grid and reads columns out as pixels.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries requests. tuser selects record (0) or column readout (1).
//   A record bins frame_time into a row and batch_count into a column and
//   bumps that cell, saturating. A readout of an existing column produces
//   ROWS pixel transfers on m_axis, row 0 first, tlast on the final row;
//   a readout of a column past the grid produces nothing.
//   The cfg channel writes registers at any time the block is idle; it is
//   always ready.
// Operation:
//   The intake bins a record with row and column restoring dividers that step
//   together; a record then reads its cell in B_IDLE and writes it back in
//   B_REC_WRITE. Intake and execution run concurrently through a two-entry
//   command queue.
//   A readout runs a peak scan over the column, then the 8-step normalizing
//   divider for each row.
// Reset:
//   After reset the cell memory is swept to zero, one entry per cycle, all
//   ROWS * 2^ceil(log2(COLUMNS)) entries (2048 by default); s_axis_tready
//   stays low during the sweep. A stalled m_axis holds the pixel register and
//   stops the readout; the intake keeps accepting until the queue fills.
// ----------------------------------------------------------------------------
module frame_batch_histogram #(
    parameter int ROWS    = 32,
    parameter int COLUMNS = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // frame_time [31:0], batch_count [51:32], column [61:52], zero [63:62]
    input  logic [fbh_pkg::S_DATA_W-1:0]      s_axis_tdata,
    // req_type [0]
    input  logic [0:0]                        s_axis_tuser,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // row [5:0], intensity [13:6], red [21:14], green [29:22],
    // alpha [37:30], zero [39:38]
    output logic [fbh_pkg::M_DATA_W-1:0]      m_axis_tdata,
    output logic                              m_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fbh_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [fbh_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int CMD_W = 1 + ROW_W + COL_W;

    fbh_pkg::fbh_cfg_t cfg_reg;

    logic                             clearing;
    logic                             cmd_in_valid, cmd_in_ready;
    logic [CMD_W-1:0]                 cmd_in_data;
    logic                             cmd_out_valid, cmd_out_ready;
    logic [CMD_W-1:0]                 cmd_out_data;
    logic [fbh_pkg::ROW_OUT_W-1:0]    px_row;
    logic [fbh_pkg::LEVEL_W-1:0]      px_intensity, px_red, px_green, px_alpha;

    // Configuration registers; unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.time_floor     <= fbh_pkg::TIME_FLOOR_RST;
            cfg_reg.time_bin_width <= fbh_pkg::TIME_BIN_WIDTH_RST;
            cfg_reg.batch_divisor  <= fbh_pkg::BATCH_DIVISOR_RST;
            cfg_reg.color_mode     <= fbh_pkg::COLOR_MODE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                fbh_pkg::REG_TIME_FLOOR:
                begin
                    cfg_reg.time_floor <= cfg_data;
                end
                fbh_pkg::REG_TIME_BIN_WIDTH:
                begin
                    cfg_reg.time_bin_width <= cfg_data;
                end
                fbh_pkg::REG_BATCH_DIVISOR:
                begin
                    cfg_reg.batch_divisor <= cfg_data[fbh_pkg::DIV_W-1:0];
                end
                fbh_pkg::REG_COLOR_MODE:
                begin
                    cfg_reg.color_mode <= cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Intake: accept requests and bin records
    fbh_front #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS),
        .ROW_W   (ROW_W),
        .COL_W   (COL_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .hold        (clearing),
        .s_valid     (s_axis_tvalid),
        .s_ready     (s_axis_tready),
        .req_type    (s_axis_tuser[0]),
        .frame_time  (s_axis_tdata[31:0]),
        .batch_count (s_axis_tdata[51:32]),
        .column      (s_axis_tdata[61:52]),
        .cmd_valid   (cmd_in_valid),
        .cmd_ready   (cmd_in_ready),
        .cmd_data    (cmd_in_data)
    );

    // Decouple intake from execution
    fbh_cmd_fifo #(
        .W     (CMD_W),
        .DEPTH (2)
    ) u_cmd_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd_in_valid),
        .in_ready  (cmd_in_ready),
        .in_data   (cmd_in_data),
        .out_valid (cmd_out_valid),
        .out_ready (cmd_out_ready),
        .out_data  (cmd_out_data)
    );

    // Execution: cell memory, peak scan, normalization, pixel register
    fbh_back #(
        .ROWS  (ROWS),
        .ROW_W (ROW_W),
        .COL_W (COL_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .color_mode  (cfg_reg.color_mode),
        .cmd_valid   (cmd_out_valid),
        .cmd_ready   (cmd_out_ready),
        .cmd_data    (cmd_out_data),
        .clearing    (clearing),
        .m_valid     (m_axis_tvalid),
        .m_ready     (m_axis_tready),
        .m_row       (px_row),
        .m_intensity (px_intensity),
        .m_red       (px_red),
        .m_green     (px_green),
        .m_alpha     (px_alpha),
        .m_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, px_alpha, px_green, px_red, px_intensity, px_row};

endmodule

[design/fbh_front.sv]
// ----------------------------------------------------------------------------
// fbh_front: request intake and binning
// Accepts requests, bins records with row and column restoring dividers and
// hands one command per record or in-grid readout to the command queue.
// ----------------------------------------------------------------------------
module fbh_front #(
    parameter int ROWS    = 32,
    parameter int COLUMNS = 64,
    parameter int ROW_W   = 5,
    parameter int COL_W   = 6
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fbh_pkg::fbh_cfg_t             cfg,
    input  logic                          hold,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          req_type,
    input  logic [fbh_pkg::TIME_W-1:0]    frame_time,
    input  logic [fbh_pkg::BATCH_W-1:0]   batch_count,
    input  logic [fbh_pkg::COLSEL_W-1:0]  column,
    output logic                          cmd_valid,
    input  logic                          cmd_ready,
    output logic [ROW_W+COL_W:0]          cmd_data
);

    localparam int SB      = (ROW_W > COL_W) ? ROW_W : COL_W;
    localparam int STEP_W  = $clog2(SB + 1);
    localparam int RDSR_W  = fbh_pkg::TIME_W + ROW_W;
    localparam int CDSR_W  = fbh_pkg::BATCH_W + COL_W;

    fbh_pkg::front_state_t             state_reg, state_next;
    logic [STEP_W-1:0]                 step_reg, step_next;
    logic [fbh_pkg::TIME_W-1:0]        rrem_reg, rrem_next;
    logic [RDSR_W-1:0]                 rdsr_reg, rdsr_next;
    logic [ROW_W:0]                    rq_reg, rq_next;
    logic [fbh_pkg::BATCH_W-1:0]       crem_reg, crem_next;
    logic [CDSR_W-1:0]                 cdsr_reg, cdsr_next;
    logic [COL_W:0]                    cq_reg, cq_next;
    logic                              kind_reg, kind_next;

    logic                              accept;
    logic [fbh_pkg::TIME_W-1:0]        bin_width;
    logic [fbh_pkg::DIV_W-1:0]         divisor;
    logic [fbh_pkg::TIME_W-1:0]        diff;
    logic                              col_ok;
    logic                              r_act, c_act, r_ge, c_ge;
    logic [ROW_W-1:0]                  row_bin;
    logic [COL_W-1:0]                  col_bin;

    assign s_ready   = (state_reg == fbh_pkg::F_IDLE) && !hold;
    assign accept    = s_valid && s_ready;
    assign bin_width = (cfg.time_bin_width == '0) ? fbh_pkg::TIME_W'(1) : cfg.time_bin_width;
    assign divisor   = (cfg.batch_divisor == '0) ? fbh_pkg::DIV_W'(1) : cfg.batch_divisor;
    assign diff      = (frame_time >= cfg.time_floor) ? (frame_time - cfg.time_floor) : '0;
    assign col_ok    = ((fbh_pkg::COLSEL_W + 1)'(column) < (fbh_pkg::COLSEL_W + 1)'(COLUMNS));

    assign r_act = (step_reg <= STEP_W'(ROW_W));
    assign c_act = (step_reg <= STEP_W'(COL_W));
    assign r_ge  = (RDSR_W'(rrem_reg) >= rdsr_reg);
    assign c_ge  = (CDSR_W'(crem_reg) >= cdsr_reg);

    // Clamp the quotients to the last row / column
    assign row_bin = (rq_reg >= (ROW_W + 1)'(ROWS)) ? ROW_W'(ROWS - 1) : rq_reg[ROW_W-1:0];
    assign col_bin = (cq_reg >= (COL_W + 1)'(COLUMNS)) ? COL_W'(COLUMNS - 1) : cq_reg[COL_W-1:0];

    assign cmd_valid = (state_reg == fbh_pkg::F_PUSH);
    assign cmd_data  = {kind_reg, row_bin, col_bin};

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        rrem_next  = rrem_reg;
        rdsr_next  = rdsr_reg;
        rq_next    = rq_reg;
        crem_next  = crem_reg;
        cdsr_next  = cdsr_reg;
        cq_next    = cq_reg;
        kind_next  = kind_reg;
        unique case (state_reg)
            fbh_pkg::F_IDLE:
            begin
                if (accept)
                begin
                    kind_next = req_type;
                    if (req_type == fbh_pkg::REQ_READOUT)
                    begin
                        // Drop readouts of columns that do not exist
                        rq_next = '0;
                        cq_next = {1'b0, column[COL_W-1:0]};
                        if (col_ok)
                        begin
                            state_next = fbh_pkg::F_PUSH;
                        end
                    end
                    else
                    begin
                        rrem_next  = diff;
                        rdsr_next  = RDSR_W'(bin_width) << ROW_W;
                        crem_next  = batch_count;
                        cdsr_next  = CDSR_W'(divisor) << COL_W;
                        rq_next    = '0;
                        cq_next    = '0;
                        step_next  = STEP_W'(SB);
                        state_next = fbh_pkg::F_DIVIDE;
                    end
                end
            end
            fbh_pkg::F_DIVIDE:
            begin
                if (r_act)
                begin
                    if (r_ge)
                    begin
                        rrem_next = rrem_reg - rdsr_reg[fbh_pkg::TIME_W-1:0];
                    end
                    rq_next   = {rq_reg[ROW_W-1:0], r_ge};
                    rdsr_next = rdsr_reg >> 1;
                end
                if (c_act)
                begin
                    if (c_ge)
                    begin
                        crem_next = crem_reg - cdsr_reg[fbh_pkg::BATCH_W-1:0];
                    end
                    cq_next   = {cq_reg[COL_W-1:0], c_ge};
                    cdsr_next = cdsr_reg >> 1;
                end
                if (step_reg == '0)
                begin
                    state_next = fbh_pkg::F_PUSH;
                end
                else
                begin
                    step_next = step_reg - STEP_W'(1);
                end
            end
            fbh_pkg::F_PUSH:
            begin
                if (cmd_ready)
                begin
                    state_next = fbh_pkg::F_IDLE;
                end
            end
            default:
            begin
                state_next = fbh_pkg::F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fbh_pkg::F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        rrem_reg <= rrem_next;
        rdsr_reg <= rdsr_next;
        rq_reg   <= rq_next;
        crem_reg <= crem_next;
        cdsr_reg <= cdsr_next;
        cq_reg   <= cq_next;
        kind_reg <= kind_next;
    end

endmodule

[design/fbh_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// fbh_cmd_fifo: command queue between intake and execution
// Small register queue; DEPTH must be a power of two.
// ----------------------------------------------------------------------------
module fbh_cmd_fifo #(
    parameter int W     = 12,
    parameter int DEPTH = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W-1:0] out_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push, pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

[design/fbh_back.sv]
// ----------------------------------------------------------------------------
// fbh_back: cell store and command execution
// Clears the counter memory after reset, increments cells for records,
// and for readouts scans a column for its peak, then normalizes each row
// with a bit-serial divider and presents one pixel per row.
// ----------------------------------------------------------------------------
module fbh_back #(
    parameter int ROWS  = 32,
    parameter int ROW_W = 5,
    parameter int COL_W = 6
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           color_mode,
    input  logic                           cmd_valid,
    output logic                           cmd_ready,
    input  logic [ROW_W+COL_W:0]           cmd_data,
    output logic                           clearing,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [fbh_pkg::ROW_OUT_W-1:0]  m_row,
    output logic [fbh_pkg::LEVEL_W-1:0]    m_intensity,
    output logic [fbh_pkg::LEVEL_W-1:0]    m_red,
    output logic [fbh_pkg::LEVEL_W-1:0]    m_green,
    output logic [fbh_pkg::LEVEL_W-1:0]    m_alpha,
    output logic                           m_last
);

    localparam int AW     = ROW_W + COL_W;
    localparam int DEPTH  = ROWS * (2 ** COL_W);
    localparam int CW     = fbh_pkg::COUNT_W;
    localparam int LW     = fbh_pkg::LEVEL_W;
    localparam int NUM_W  = CW + LW;
    localparam int NDSR_W = CW + LW - 1;
    localparam int BIT_W  = $clog2(LW);

    logic [CW-1:0] cell_mem [DEPTH];
    logic [CW-1:0] rd_data_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [CW-1:0] mem_wdata;

    fbh_pkg::back_state_t state_reg, state_next;
    logic [AW-1:0]        addr_reg, addr_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic [COL_W-1:0]     col_reg, col_next;
    logic [CW-1:0]        peak_reg, peak_next;
    logic [NUM_W-1:0]     rem_reg, rem_next;
    logic [NDSR_W-1:0]    dsr_reg, dsr_next;
    logic [LW-1:0]        q_reg, q_next;
    logic [BIT_W-1:0]     bit_reg, bit_next;
    logic                 out_valid_reg;

    logic                 cmd_kind;
    logic [ROW_W-1:0]     cmd_row;
    logic [COL_W-1:0]     cmd_col;
    logic                 last_row;
    logic                 out_free, load_out, ge;
    logic [LW-1:0]        level;

    assign cmd_kind = cmd_data[ROW_W+COL_W];
    assign cmd_row  = cmd_data[ROW_W+COL_W-1 -: ROW_W];
    assign cmd_col  = cmd_data[COL_W-1:0];
    assign last_row = (row_reg == ROW_W'(ROWS - 1));
    assign out_free = !out_valid_reg || m_ready;
    assign ge       = (rem_reg >= NUM_W'(dsr_reg));
    assign level    = (q_reg > LW'(1)) ? (q_reg - LW'(1)) : q_reg;
    assign clearing = (state_reg == fbh_pkg::B_CLEAR);
    assign m_valid  = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        peak_next  = peak_reg;
        rem_next   = rem_reg;
        dsr_next   = dsr_reg;
        q_next     = q_reg;
        bit_next   = bit_reg;
        mem_we     = 1'b0;
        mem_waddr  = {row_reg, col_reg};
        mem_wdata  = (rd_data_reg == '1) ? rd_data_reg : (rd_data_reg + CW'(1));
        mem_raddr  = {row_reg, col_reg};
        cmd_ready  = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            fbh_pkg::B_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = addr_reg;
                mem_wdata = '0;
                if (addr_reg == AW'(DEPTH - 1))
                begin
                    state_next = fbh_pkg::B_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + AW'(1);
                end
            end
            fbh_pkg::B_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    col_next = cmd_col;
                    if (cmd_kind == fbh_pkg::REQ_RECORD)
                    begin
                        row_next   = cmd_row;
                        mem_raddr  = {cmd_row, cmd_col};
                        state_next = fbh_pkg::B_REC_WRITE;
                    end
                    else
                    begin
                        row_next   = '0;
                        mem_raddr  = {ROW_W'(0), cmd_col};
                        peak_next  = CW'(1);
                        state_next = fbh_pkg::B_SCAN;
                    end
                end
            end
            fbh_pkg::B_REC_WRITE:
            begin
                // Saturating increment of the cell read last cycle
                mem_we     = 1'b1;
                state_next = fbh_pkg::B_IDLE;
            end
            fbh_pkg::B_SCAN:
            begin
                if (rd_data_reg > peak_reg)
                begin
                    peak_next = rd_data_reg;
                end
                if (last_row)
                begin
                    row_next   = '0;
                    mem_raddr  = {ROW_W'(0), col_reg};
                    state_next = fbh_pkg::B_NORM_LOAD;
                end
                else
                begin
                    row_next  = row_reg + ROW_W'(1);
                    mem_raddr = {row_reg + ROW_W'(1), col_reg};
                end
            end
            fbh_pkg::B_NORM_LOAD:
            begin
                rem_next   = NUM_W'(rd_data_reg) * NUM_W'(fbh_pkg::LEVEL_SCALE);
                dsr_next   = NDSR_W'(peak_reg) << (LW - 1);
                q_next     = '0;
                bit_next   = BIT_W'(LW - 1);
                state_next = fbh_pkg::B_NORM_DIV;
            end
            fbh_pkg::B_NORM_DIV:
            begin
                if (ge)
                begin
                    rem_next = rem_reg - NUM_W'(dsr_reg);
                end
                q_next   = {q_reg[LW-2:0], ge};
                dsr_next = dsr_reg >> 1;
                if (bit_reg == '0)
                begin
                    state_next = fbh_pkg::B_EMIT;
                end
                else
                begin
                    bit_next = bit_reg - BIT_W'(1);
                end
            end
            fbh_pkg::B_EMIT:
            begin
                if (out_free)
                begin
                    load_out = 1'b1;
                    if (last_row)
                    begin
                        state_next = fbh_pkg::B_IDLE;
                    end
                    else
                    begin
                        row_next   = row_reg + ROW_W'(1);
                        mem_raddr  = {row_reg + ROW_W'(1), col_reg};
                        state_next = fbh_pkg::B_NORM_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = fbh_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cell_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= cell_mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fbh_pkg::B_CLEAR;
            addr_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg  <= row_next;
        col_reg  <= col_next;
        peak_reg <= peak_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
        q_reg    <= q_next;
        bit_reg  <= bit_next;
        if (load_out)
        begin
            m_row       <= fbh_pkg::ROW_OUT_W'(row_reg);
            m_intensity <= level;
            m_red       <= (color_mode == fbh_pkg::COLOR_RED) ? level : '0;
            m_green     <= (color_mode == fbh_pkg::COLOR_GREEN) ? level : '0;
            m_alpha     <= (level != '0) ? fbh_pkg::ALPHA_ON : '0;
            m_last      <= last_row;
        end
    end

endmodule

[design/fbh_checker.sv]
// ----------------------------------------------------------------------------
// fbh_checker: port-level checks for the frame/batch histogram
// Watches the pixel stream and the reset sweep at the top-level ports.
// ----------------------------------------------------------------------------
module fbh_checker #(
    parameter int ROWS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tready,
    input  logic [fbh_pkg::M_DATA_W-1:0]  m_axis_tdata,
    input  logic                          m_axis_tlast,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready
);

    logic [fbh_pkg::ROW_OUT_W-1:0] px_row;
    logic [fbh_pkg::LEVEL_W-1:0]   px_intensity, px_alpha;

    assign px_row       = m_axis_tdata[5:0];
    assign px_intensity = m_axis_tdata[13:6];
    assign px_alpha     = m_axis_tdata[37:30];

    // Memory sweep: no intake and no pixel right after reset release
    a_reset_sweep: assert property (@(posedge clk)
        $rose(rst_n) |-> !s_axis_tready && !m_axis_tvalid)
        else $error("intake open or pixel valid right after reset");

    // tlast marks exactly the final row
    a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (px_row == fbh_pkg::ROW_OUT_W'(ROWS - 1))))
        else $error("tlast does not match final row");

    // Within a run, a pixel that follows a transfer directly is the next row
    a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) ##1 m_axis_tvalid |->
        (px_row == fbh_pkg::ROW_OUT_W'($past(px_row) + 1'b1)))
        else $error("pixel rows out of sequence");

    // Alpha follows intensity
    a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((px_alpha == fbh_pkg::ALPHA_ON) == (px_intensity != '0)))
        else $error("alpha inconsistent with intensity");

    // Stalled pixel holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled pixel changed");

endmodule

bind frame_batch_histogram fbh_checker #(
    .ROWS (ROWS)
) u_fbh_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);
